@@ hdl/tvfs_pkg.sv @@
// Package: shared constants, state encoding and controller/datapath bundles.
`timescale 1ns / 1ps
package tvfs_pkg;
    localparam int GRID_SIDE      = 16;
    localparam int COORD_BITS     = $clog2(GRID_SIDE);
    localparam int FRAC_BITS      = 8;
    localparam int POS_BITS       = COORD_BITS + FRAC_BITS;
    localparam int COMPONENT_BITS = 16;
    localparam int ADDR_BITS      = 3 * COORD_BITS;
    localparam int SLICE_BITS     = 5;
    localparam int BLEND_STEPS    = 7;
    localparam int SLICE_LOW      = 2;
    localparam int SLICE_MARGIN   = 3;

    // Operation codes of an input transfer
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_BLEND,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic                 capture;
        logic                 mem_clear;
        logic [ADDR_BITS-1:0] clear_addr;
        logic                 mem_write;
        logic                 rd_en;
        logic [2:0]           corner;
        logic                 blend_en;
        logic [2:0]           step;
        logic                 load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_status;
endpackage

@@ hdl/tvfs_ctrl.sv @@
// Controller: sequences store clearing, voxel writes, corner reads and blend steps.
`timescale 1ns / 1ps
module tvfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_operation,
    output logic             o_in_ready,
    input  tvfs_pkg::t_status i_status,
    output tvfs_pkg::t_cmd    o_cmd
);
    import tvfs_pkg::*;

    t_state                r_state, n_state;
    logic [ADDR_BITS-1:0]  r_cnt, n_cnt;
    logic                  accept;

    assign accept = (r_state == ST_IDLE) && i_in_valid;

    // State and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = (i_operation == OP_QUERY) ? ST_READ : ST_WRITE;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_READ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_state = ST_BLEND;
                    n_cnt   = '0;
                end
            end
            ST_BLEND: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[2:0] == 3'(BLEND_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.clear_addr = r_cnt;
        o_cmd.corner     = r_cnt[2:0];
        o_cmd.step       = r_cnt[2:0];
        o_in_ready       = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.mem_clear = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = accept;
            end
            ST_WRITE: o_cmd.mem_write = 1'b1;
            ST_READ:  o_cmd.rd_en     = 1'b1;
            ST_BLEND: o_cmd.blend_en  = 1'b1;
            ST_OUT:   o_cmd.load_out  = !i_status.out_busy;
            default:  o_cmd.capture   = 1'b0;
        endcase
    end
endmodule

@@ hdl/tvfs_datapath.sv @@
// Datapath: voxel memory, corner registers, shared blend unit and output register.
`timescale 1ns / 1ps
module tvfs_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tvfs_pkg::t_cmd                          i_cmd,
    output tvfs_pkg::t_status                       o_status,
    input  logic [tvfs_pkg::SLICE_BITS-1:0]         i_slice_count,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_x,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_y,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_z,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vx,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vy,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vz,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vx,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vy,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vz,
    output logic                                    o_outside_grid
);
    import tvfs_pkg::*;
    localparam int CB = COMPONENT_BITS;
    localparam int VB = 3 * CB;
    localparam int PB = CB + FRAC_BITS + 3;

    logic [POS_BITS-1:0]     r_px, r_py, r_pz;
    logic [VB-1:0]           r_wvec;
    logic [VB-1:0]           r_mem [GRID_SIDE**3];
    logic [VB-1:0]           r_mem_q;
    logic                    r_rd_vld, r_rd_zero;
    logic [2:0]              r_rd_idx;
    logic [VB-1:0]           r_c [8];
    logic [VB-1:0]           r_e [BLEND_STEPS];
    logic                    r_outside;
    logic                    r_out_valid;

    logic [COORD_BITS:0]     cx, cy, cz;
    logic                    c_out, c_zero;
    logic [SLICE_BITS:0]     cx_top;
    logic [ADDR_BITS-1:0]    waddr, raddr;
    logic                    wr_en, w_in_grid;
    logic [VB-1:0]           wdata;
    logic [VB-1:0]           bl_a, bl_b, bl_r;
    logic [FRAC_BITS-1:0]    bl_f;

    // Corner coordinates and range checks
    assign cx     = {1'b0, r_px[POS_BITS-1 -: COORD_BITS]} + (COORD_BITS+1)'(i_cmd.corner[2]);
    assign cy     = {1'b0, r_py[POS_BITS-1 -: COORD_BITS]} + (COORD_BITS+1)'(i_cmd.corner[1]);
    assign cz     = {1'b0, r_pz[POS_BITS-1 -: COORD_BITS]} + (COORD_BITS+1)'(i_cmd.corner[0]);
    assign c_out  = cx[COORD_BITS] | cy[COORD_BITS] | cz[COORD_BITS];
    assign cx_top = (SLICE_BITS+1)'(cx) + (SLICE_BITS+1)'(SLICE_MARGIN);
    assign c_zero = c_out || (cx < (COORD_BITS+1)'(SLICE_LOW))
                    || (cx_top > {1'b0, i_slice_count});
    assign raddr  = {cx[COORD_BITS-1:0], cy[COORD_BITS-1:0], cz[COORD_BITS-1:0]};

    // Write port: clearing sweep or voxel write
    assign waddr = i_cmd.mem_clear ? i_cmd.clear_addr
                 : {r_px[POS_BITS-1 -: COORD_BITS], r_py[POS_BITS-1 -: COORD_BITS],
                    r_pz[POS_BITS-1 -: COORD_BITS]};
    assign w_in_grid = 1'b1;
    assign wr_en = i_cmd.mem_clear || (i_cmd.mem_write && w_in_grid);
    assign wdata = i_cmd.mem_clear ? '0 : r_wvec;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_wvec <= {i_write_vx, i_write_vy, i_write_vz};
        end
    end

    // Voxel memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[raddr];
        end
    end

    // Read return tracking and outside flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
        r_rd_zero <= c_zero;
        r_rd_idx  <= i_cmd.corner;
        if (i_cmd.capture) begin
            r_outside <= 1'b0;
        end else if (i_cmd.rd_en && c_out) begin
            r_outside <= 1'b1;
        end
        if (r_rd_vld) begin
            r_c[r_rd_idx] <= r_rd_zero ? '0 : r_mem_q;
        end
    end

    // Blend operand selection: z pairs, then y pairs, then x
    always_comb begin
        bl_a = r_e[4];
        bl_b = r_e[5];
        bl_f = r_px[FRAC_BITS-1:0];
        case (i_cmd.step)
            3'd0: begin bl_a = r_c[0]; bl_b = r_c[1]; bl_f = r_pz[FRAC_BITS-1:0]; end
            3'd1: begin bl_a = r_c[2]; bl_b = r_c[3]; bl_f = r_pz[FRAC_BITS-1:0]; end
            3'd2: begin bl_a = r_c[4]; bl_b = r_c[5]; bl_f = r_pz[FRAC_BITS-1:0]; end
            3'd3: begin bl_a = r_c[6]; bl_b = r_c[7]; bl_f = r_pz[FRAC_BITS-1:0]; end
            3'd4: begin bl_a = r_e[0]; bl_b = r_e[1]; bl_f = r_py[FRAC_BITS-1:0]; end
            3'd5: begin bl_a = r_e[2]; bl_b = r_e[3]; bl_f = r_py[FRAC_BITS-1:0]; end
            default: begin bl_a = r_e[4]; bl_b = r_e[5]; bl_f = r_px[FRAC_BITS-1:0]; end
        endcase
    end

    // Shared blend unit, one lane per component, round half up then saturate
    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [CB-1:0]        a, b;
        logic signed [FRAC_BITS+1:0] wf, wn;
        logic signed [PB-1:0]        t, q;
        assign a  = bl_a[k*CB +: CB];
        assign b  = bl_b[k*CB +: CB];
        assign wf = $signed({2'b00, bl_f});
        assign wn = $signed((FRAC_BITS+2)'(1 << FRAC_BITS)) - wf;
        assign t  = PB'(a * wn) + PB'(b * wf) + PB'(1 << (FRAC_BITS - 1));
        assign q  = t >>> FRAC_BITS;
        always_comb begin
            if (q > PB'((1 << (CB-1)) - 1)) begin
                bl_r[k*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
            end else if (q < -PB'(1 << (CB-1))) begin
                bl_r[k*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
            end else begin
                bl_r[k*CB +: CB] = q[CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blend_en) begin
            r_e[i_cmd.step] <= bl_r;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            o_result_vx    <= r_e[BLEND_STEPS-1][2*CB +: CB];
            o_result_vy    <= r_e[BLEND_STEPS-1][CB +: CB];
            o_result_vz    <= r_e[BLEND_STEPS-1][0 +: CB];
            o_outside_grid <= r_outside;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
endmodule

@@ hdl/trilinear_vector_field_sampler.sv @@
// Top level: trilinear sampler of a 16x16x16 grid of 3-component vectors.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready     | i_operation, i_pos_x/y/z, i_write_vx/vy/vz
//  output   | o_out_valid / i_out_ready   | o_result_vx/vy/vz, o_outside_grid
//  config   | i_cfg_we (no wait)          | i_cfg_data (slice_count)
//
//  A write stores the captured voxel and returns to idle; a query makes 8 corner reads through the single
//  memory read port, then 7 blend steps in the shared blend unit, then output load.
//  After reset a clearing pass zeroes the store, with o_in_ready low.
//  A finished result waits in the output register; the next item is taken meanwhile,
//  and a query only stalls at output load while the previous result is still held.
`timescale 1ns / 1ps
module trilinear_vector_field_sampler (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [tvfs_pkg::SLICE_BITS-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_operation,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_x,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_y,
    input  logic [tvfs_pkg::POS_BITS-1:0]           i_pos_z,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vx,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vy,
    input  logic signed [tvfs_pkg::COMPONENT_BITS-1:0] i_write_vz,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vx,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vy,
    output logic signed [tvfs_pkg::COMPONENT_BITS-1:0] o_result_vz,
    output logic                                    o_outside_grid
);
    import tvfs_pkg::*;

    t_cmd                  cmd;
    t_status               status;
    logic [SLICE_BITS-1:0] r_slice_count;

    // Slice count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count <= SLICE_BITS'(GRID_SIDE);
        end else if (i_cfg_we) begin
            r_slice_count <= i_cfg_data;
        end
    end

    tvfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tvfs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_slice_count  (r_slice_count),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_write_vx     (i_write_vx),
        .i_write_vy     (i_write_vy),
        .i_write_vz     (i_write_vz),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_vx    (o_result_vx),
        .o_result_vy    (o_result_vy),
        .o_result_vz    (o_result_vz),
        .o_outside_grid (o_outside_grid)
    );
endmodule

@@ hdl/tvfs_checker.sv @@
// Checker: port-level properties of the sampler, bound to the top level.
`timescale 1ns / 1ps
module tvfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_operation,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_result_vx,
    input logic        o_outside_grid
);
    import tvfs_pkg::*;

    // Reset starts the clearing pass: no result and no input transfer
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("block not quiet after reset");

    // A query keeps the block busy for the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_QUERY)) |=> !o_in_ready)
        else $error("input taken while a query is in progress");

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_result_vx) && $stable(o_outside_grid)))
        else $error("result changed while stalled");
endmodule

bind trilinear_vector_field_sampler tvfs_checker u_tvfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_operation    (i_operation),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_vx    (o_result_vx),
    .o_outside_grid (o_outside_grid)
);

@@ test/trilinear_vector_field_sampler_test.sv @@
// Testbench for the trilinear vector field sampler: queued driver, output monitor, predictor.
`timescale 1ns / 1ps
module trilinear_vector_field_sampler_test;
    import tvfs_pkg::*;

    localparam int   LIMIT_CYCLES = 300000;
    localparam int   HOLD_CYCLES = 400;
    localparam int   SETTLE_CYCLES = 40;

    typedef struct packed {
        logic                             op;
        logic [POS_BITS-1:0]              px;
        logic [POS_BITS-1:0]              py;
        logic [POS_BITS-1:0]              pz;
        logic signed [COMPONENT_BITS-1:0] vx;
        logic signed [COMPONENT_BITS-1:0] vy;
        logic signed [COMPONENT_BITS-1:0] vz;
    } t_sample_req;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] vx;
        logic signed [COMPONENT_BITS-1:0] vy;
        logic signed [COMPONENT_BITS-1:0] vz;
        logic                             outside;
    } t_blend_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SLICE_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_operation = 1'b0;
    logic [POS_BITS-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [COMPONENT_BITS-1:0] i_write_vx = '0, i_write_vy = '0, i_write_vz = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [COMPONENT_BITS-1:0] o_result_vx, o_result_vy, o_result_vz;
    logic o_outside_grid;

    trilinear_vector_field_sampler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_operation(i_operation),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_write_vx(i_write_vx), .i_write_vy(i_write_vy), .i_write_vz(i_write_vz),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_vx(o_result_vx), .o_result_vy(o_result_vy), .o_result_vz(o_result_vz),
        .o_outside_grid(o_outside_grid)
    );

    // Clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the grid and the slice register
    logic signed [COMPONENT_BITS-1:0] grid_x [GRID_SIDE**3];
    logic signed [COMPONENT_BITS-1:0] grid_y [GRID_SIDE**3];
    logic signed [COMPONENT_BITS-1:0] grid_z [GRID_SIDE**3];
    logic [SLICE_BITS-1:0] live_slices = SLICE_BITS'(16);

    t_sample_req pending_reqs[$];
    t_blend_vec  expected_vecs[$];
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          queries_sent = 0, writes_sent = 0, results_seen = 0, outside_seen = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // One blend step: round half up, floor division by 2^FRAC_BITS
    function automatic longint lerp_step(longint a, longint b, longint f);
        longint t;
        t = a * ((longint'(1) << FRAC_BITS) - f) + b * f + (longint'(1) << (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic t_blend_vec sample_field(t_sample_req r);
        longint c[2][2][2][3];
        longint e0, e1, e2, e3, g0, g1, v;
        int ix, iy, iz, cx, cy, cz, a;
        longint fx, fy, fz;
        t_blend_vec res;
        ix = int'(r.px >> FRAC_BITS); iy = int'(r.py >> FRAC_BITS); iz = int'(r.pz >> FRAC_BITS);
        fx = longint'(r.px[FRAC_BITS-1:0]);
        fy = longint'(r.py[FRAC_BITS-1:0]);
        fz = longint'(r.pz[FRAC_BITS-1:0]);
        res.outside = 1'b0;
        for (int dx = 0; dx < 2; dx++)
            for (int dy = 0; dy < 2; dy++)
                for (int dz = 0; dz < 2; dz++) begin
                    cx = ix + dx; cy = iy + dy; cz = iz + dz;
                    for (int k = 0; k < 3; k++) c[dx][dy][dz][k] = 0;
                    if (cx >= GRID_SIDE || cy >= GRID_SIDE || cz >= GRID_SIDE) begin
                        res.outside = 1'b1;
                    end else if (cx >= SLICE_LOW && cx <= int'(live_slices) - SLICE_MARGIN) begin
                        a = (cx * GRID_SIDE + cy) * GRID_SIDE + cz;
                        c[dx][dy][dz][0] = longint'(grid_x[a]);
                        c[dx][dy][dz][1] = longint'(grid_y[a]);
                        c[dx][dy][dz][2] = longint'(grid_z[a]);
                    end
                end
        for (int k = 0; k < 3; k++) begin
            e0 = lerp_step(c[0][0][0][k], c[0][0][1][k], fz);
            e1 = lerp_step(c[0][1][0][k], c[0][1][1][k], fz);
            e2 = lerp_step(c[1][0][0][k], c[1][0][1][k], fz);
            e3 = lerp_step(c[1][1][0][k], c[1][1][1][k], fz);
            g0 = lerp_step(e0, e1, fy);
            g1 = lerp_step(e2, e3, fy);
            v = lerp_step(g0, g1, fx);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            if (k == 0) res.vx = v[15:0];
            else if (k == 1) res.vy = v[15:0];
            else res.vz = v[15:0];
        end
        return res;
    endfunction

    // Apply an accepted item to the shadow grid or queue its result
    function automatic void track_transfer(t_sample_req r);
        int a;
        if (r.op == OP_WRITE) begin
            a = (int'(r.px >> FRAC_BITS) * GRID_SIDE + int'(r.py >> FRAC_BITS)) * GRID_SIDE
                + int'(r.pz >> FRAC_BITS);
            grid_x[a] = r.vx; grid_y[a] = r.vy; grid_z[a] = r.vz;
            writes_sent++;
        end else begin
            expected_vecs.push_back(sample_field(r));
            queries_sent++;
        end
    endfunction

    // Driver: offers queued items, random gaps unless no_idle is set
    always @(posedge i_clk) begin
        t_sample_req nxt;
        bit accepted;
        accepted = i_in_valid && o_in_ready;
        if (accepted)
            track_transfer({i_operation, i_pos_x, i_pos_y, i_pos_z,
                            i_write_vx, i_write_vy, i_write_vz});
        if (i_rst_n && (!i_in_valid || accepted)) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                nxt = pending_reqs.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= nxt.op;
                i_pos_x <= nxt.px; i_pos_y <= nxt.py; i_pos_z <= nxt.pz;
                i_write_vx <= nxt.vx; i_write_vy <= nxt.vy; i_write_vz <= nxt.vz;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer and drives output ready
    always @(posedge i_clk) begin
        t_blend_vec want;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_outside_grid) outside_seen++;
            if (expected_vecs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result vx=%0d vy=%0d vz=%0d outside=%0b",
                             o_result_vx, o_result_vy, o_result_vz, o_outside_grid);
            end else begin
                want = expected_vecs.pop_front();
                if (o_result_vx !== want.vx || o_result_vy !== want.vy ||
                    o_result_vz !== want.vz || o_outside_grid !== want.outside) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                                 results_seen, want.vx, want.vy, want.vz, want.outside,
                                 o_result_vx, o_result_vy, o_result_vz, o_outside_grid);
                end
            end
        end
        // long hold-off once, so the block backs up and stalls its input
        if (!hold_done && results_seen == 30) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_sample_req make_req(logic op, int px, int py, int pz,
                                              int vx, int vy, int vz);
        t_sample_req r;
        r.op = op;
        r.px = POS_BITS'(px); r.py = POS_BITS'(py); r.pz = POS_BITS'(pz);
        r.vx = COMPONENT_BITS'(vx); r.vy = COMPONENT_BITS'(vy); r.vz = COMPONENT_BITS'(vz);
        return r;
    endfunction

    function automatic int pick_component();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Random item: three in four items fall in a small box so queries hit written data
    function automatic t_sample_req random_req();
        int bx, by, bz;
        bx = $urandom_range(0, 15); by = $urandom_range(0, 15); bz = $urandom_range(0, 15);
        if ($urandom_range(0, 3) != 0) begin
            bx = $urandom_range(1, 6); by = $urandom_range(4, 6); bz = $urandom_range(4, 6);
        end
        if ($urandom_range(0, 99) < 45)
            return make_req(OP_WRITE, (bx << FRAC_BITS) | $urandom_range(0, 255),
                            (by << FRAC_BITS) | $urandom_range(0, 255),
                            (bz << FRAC_BITS) | $urandom_range(0, 255),
                            pick_component(), pick_component(), pick_component());
        return make_req(OP_QUERY, (bx << FRAC_BITS) | $urandom_range(0, 255),
                        (by << FRAC_BITS) | $urandom_range(0, 255),
                        (bz << FRAC_BITS) | $urandom_range(0, 255),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535));
    endfunction

    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || i_in_valid || expected_vecs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slices(int n);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= SLICE_BITS'(n);
        live_slices <= SLICE_BITS'(n);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    int slice_plan[8] = '{16, 5, 0, 31, 9, 4, 12, 16};

    initial begin
        for (int a = 0; a < GRID_SIDE**3; a++) begin
            grid_x[a] = '0; grid_y[a] = '0; grid_z[a] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            write_slices(slice_plan[p]);
            no_idle = (p == 2);
            if (p == 0) begin
                // corners of the grid, extreme values, points outside the grid, edge fractions
                pending_reqs.push_back(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_WRITE, 'h300, 'h300, 'h300,
                                                32767, -32768, -1));
                pending_reqs.push_back(make_req(OP_WRITE, 'h3FF, 'h3FF, 'h4FF,
                                                -32768, 32767, 1));
                pending_reqs.push_back(make_req(OP_WRITE, 'h400, 'h300, 'h300,
                                                -32768, 32767, 16384));
                pending_reqs.push_back(make_req(OP_WRITE, 'h4FF, 'h4FF, 'h4FF,
                                                32767, 32767, 32767));
                pending_reqs.push_back(make_req(OP_WRITE, 'h3AA, 'h455, 'h300,
                                                -32768, -32768, -32768));
                pending_reqs.push_back(make_req(OP_QUERY, 'h300, 'h300, 'h300, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'h3FF, 'h3FF, 'h3FF, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'h380, 'h380, 'h380, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'h37F, 'h301, 'h3C0, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_WRITE, 'h100, 'h100, 'h100,
                                                12345, -12345, 777));
                pending_reqs.push_back(make_req(OP_QUERY, 'h180, 'h100, 'h100, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_WRITE, 'hFFF, 'hFFF, 'hFFF,
                                                32767, -32768, 32767));
                pending_reqs.push_back(make_req(OP_WRITE, 'hD00, 'h000, 'h000,
                                                -1, -1, -1));
                pending_reqs.push_back(make_req(OP_QUERY, 'hFFF, 'hFFF, 'hFFF, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'hE00, 'hF00, 'h000, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'hC80, 'h000, 'h000, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'hD00, 'h000, 'h000, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'h000, 'h0FF, 'hFFF, 0, 0, 0));
                pending_reqs.push_back(make_req(OP_QUERY, 'hFFF, 'h000, 'h000,
                                                'hFFFF, 'hFFFF, 'hFFFF));
            end
            for (int n = 0; n < 92; n++)
                pending_reqs.push_back(random_req());
            drain_and_settle();
        end

        $display("covered %0d writes and %0d queries over 8 slice settings (0 to 31)",
                 writes_sent, queries_sent);
        $display("%0d results checked, %0d flagged outside the grid, %0d mismatches",
                 results_seen, outside_seen, mismatches);
        if (mismatches == 0 && expected_vecs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ trilinear_vector_field_sampler.f @@
hdl/tvfs_pkg.sv
hdl/tvfs_ctrl.sv
hdl/tvfs_datapath.sv
hdl/trilinear_vector_field_sampler.sv
hdl/tvfs_checker.sv
test/trilinear_vector_field_sampler_test.sv
